/* rtl/sliding_window_median_filter_core_macros.svh */
// Assertion macros for the median filter RTL.
// Needs clk and rst_n to be visible at the point of use.
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_CORE_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge and disabled in reset.
`define SWMF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge and disabled in reset.
`define SWMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/swmf_pkg.sv */
// Package for the sliding window median filter.
// Holds the sample type and the flag struct that passes between neighboring cells.
package swmf_pkg;

  localparam int SAMPLE_W = 16;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // Flags that one cell shows to its neighbors and to the top level.
  typedef struct packed {
    logic gt;     // stored value is greater than the incoming word
    logic evict;  // this cell holds the oldest word of the window
    logic ev_le;  // the oldest word sits in this cell or in a cell below it
  } cell_flags_t;

endpackage

/* rtl/swmf_cell.sv */
// One cell of the sorted window chain: a value and its age.
// Depends on swmf_pkg.
module swmf_cell #(
  parameter int WINDOW = 10
) (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        prime,
  input  swmf_pkg::sample_t           sample,
  input  logic [$clog2(WINDOW)-1:0]   init_age,
  input  logic                        ev_le_lo,
  input  swmf_pkg::sample_t           lo_val,
  input  logic [$clog2(WINDOW)-1:0]   lo_age,
  input  swmf_pkg::cell_flags_t       lo_flags,
  input  swmf_pkg::sample_t           hi_val,
  input  logic [$clog2(WINDOW)-1:0]   hi_age,
  input  swmf_pkg::cell_flags_t       hi_flags,
  output swmf_pkg::sample_t           val,
  output logic [$clog2(WINDOW)-1:0]   age,
  output swmf_pkg::cell_flags_t       flags,
  output swmf_pkg::sample_t           val_nxt
);
  import swmf_pkg::*;

  localparam int AGE_W = $clog2(WINDOW);
  localparam logic [AGE_W-1:0] LAST_AGE = AGE_W'(WINDOW - 1);

  sample_t          val_r;
  logic [AGE_W-1:0] age_r;
  logic [AGE_W-1:0] age_nxt;
  cell_flags_t      own;

  always_comb begin
    own.gt    = (val_r > sample);
    own.evict = (age_r == LAST_AGE);
    own.ev_le = ev_le_lo | own.evict;
  end

  // When the oldest word is at or below this cell, words up to the new one
  // slide down; otherwise words above the new one slide up. The cell holding
  // the oldest word takes its lower neighbor's word when the new word lands
  // below it.
  always_comb begin
    val_nxt = val_r;
    age_nxt = age_r + AGE_W'(1);
    if (prime) begin
      val_nxt = sample;
      age_nxt = init_age;
    end else if (own.ev_le) begin
      if (!hi_flags.gt) begin
        val_nxt = hi_val;
        age_nxt = hi_age + AGE_W'(1);
      end else if (own.evict && lo_flags.gt) begin
        val_nxt = lo_val;
        age_nxt = lo_age + AGE_W'(1);
      end else if (own.evict || !own.gt) begin
        val_nxt = sample;
        age_nxt = '0;
      end
    end else if (own.gt) begin
      if (lo_flags.gt) begin
        val_nxt = lo_val;
        age_nxt = lo_age + AGE_W'(1);
      end else begin
        val_nxt = sample;
        age_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

  assign val   = val_r;
  assign age   = age_r;
  assign flags = own;

endmodule

/* rtl/sliding_window_median_filter_core.sv */
// Running median filter over the last WINDOW unsigned 16-bit words. The window
// lives in a row of WINDOW cells kept in ascending order, each cell holding one
// word and its age. An accepted word replaces the oldest entry and is inserted
// in sorted order in the same cycle, so the block takes one word per clock while
// in_stall is low; the median reaches the output register in the next cycle.
// The cycle time is set by the 16-bit compare in each cell plus the ripple
// along the row that locates the oldest entry. The first word after reset
// fills every cell, so its median is the word itself. For an even window the
// result is the upper of the two middle words. A finished result waits in the
// output register while the next word is still taken if the output moves on
// in the same cycle.
module sliding_window_median_filter_core #(
  parameter int WINDOW = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  swmf_pkg::sample_t in_sample,
  output logic              out_valid,
  input  logic              out_stall,
  output swmf_pkg::sample_t out_median
);
  import swmf_pkg::*;

  `include "sliding_window_median_filter_core_macros.svh"

  localparam int AGE_W = $clog2(WINDOW);
  localparam int MID   = WINDOW / 2;

  // Cell row signals, index 0 holds the smallest word.
  sample_t          cell_val     [WINDOW];
  logic [AGE_W-1:0] cell_age     [WINDOW];
  cell_flags_t      cell_flags   [WINDOW];
  sample_t          cell_val_nxt [WINDOW];
  logic [WINDOW-1:0] evict_vec;

  logic    primed_r;
  logic    out_valid_r;
  sample_t median_r;
  logic    accept;

  // A new word is taken whenever the output register is empty or drains now.
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    localparam int LO = (i == 0) ? 0 : i - 1;
    localparam int HI = (i == WINDOW - 1) ? WINDOW - 1 : i + 1;

    logic        ev_le_lo;
    cell_flags_t lo_flags;
    cell_flags_t hi_flags;

    // The bottom cell sees nothing below it; the top cell sees a virtual
    // neighbor above that is larger than any word.
    always_comb begin
      ev_le_lo = (i == 0) ? 1'b0 : cell_flags[LO].ev_le;
      lo_flags = cell_flags[LO];
      hi_flags = cell_flags[HI];
      if (i == 0) begin
        lo_flags.gt = 1'b0;
      end
      if (i == WINDOW - 1) begin
        hi_flags.gt = 1'b1;
      end
    end

    swmf_cell #(
      .WINDOW (WINDOW)
    ) u_cell (
      .clk      (clk),
      .load     (accept),
      .prime    (~primed_r),
      .sample   (in_sample),
      .init_age (AGE_W'(i)),
      .ev_le_lo (ev_le_lo),
      .lo_val   (cell_val[LO]),
      .lo_age   (cell_age[LO]),
      .lo_flags (lo_flags),
      .hi_val   (cell_val[HI]),
      .hi_age   (cell_age[HI]),
      .hi_flags (hi_flags),
      .val      (cell_val[i]),
      .age      (cell_age[i]),
      .flags    (cell_flags[i]),
      .val_nxt  (cell_val_nxt[i])
    );

    assign evict_vec[i] = cell_flags[i].evict;
  end

  // Control state: the priming flag and the output valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        primed_r <= 1'b1;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The median is the middle cell of the row after the insertion.
  always_ff @(posedge clk) begin
    if (accept) begin
      median_r <= cell_val_nxt[MID];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_median = median_r;

  // Once primed, the ages form a permutation, so exactly one cell is oldest.
  `SWMF_ASSERT_IMPL(a_one_oldest, primed_r, $onehot(evict_vec), "oldest entry not unique")
  // Every accepted word leaves a result in the output register.
  `SWMF_ASSERT_NEXT(a_result_follows, accept, out_valid_r, "accepted word gave no result")
  // The first accepted word primes the window for good.
  `SWMF_ASSERT_NEXT(a_primed, accept, primed_r, "window not primed after a word")

endmodule

/* test/swmf_median_checker.sv */
// Checker for the running median filter: watches both channels, keeps its own window copy
// and compares every median word that leaves the block with the predicted one.
// Depends on swmf_pkg for the sample type.
module swmf_median_checker #(
  parameter int WINDOW = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  swmf_pkg::sample_t in_sample,
  input  logic              out_valid,
  input  logic              out_stall,
  input  swmf_pkg::sample_t out_median,
  output int                mismatches,
  output int                medians_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import swmf_pkg::*;

  sample_t     window_copy [WINDOW];
  int unsigned write_slot;
  bit          primed;
  sample_t     expected_medians [$];
  int          error_count = 0;

  // Insertion sort of the window copy; ties keep their order, which cannot
  // change the value at the middle index.
  function automatic sample_t window_median();
    sample_t ordered [WINDOW];
    int      j;
    for (int i = 0; i < WINDOW; i++) begin
      j = i;
      while (j > 0 && ordered[j-1] > window_copy[i]) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = window_copy[i];
    end
    return ordered[WINDOW/2];
  endfunction

  always @(posedge clk) begin : watch
    sample_t want;
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) window_copy[i] = '0;
      write_slot = 0;
      primed     = 1'b0;
      expected_medians.delete();
    end else begin
      if (in_valid && !in_stall) begin
        // The first word after reset fills the whole window.
        if (!primed) begin
          for (int i = 0; i < WINDOW; i++) window_copy[i] = in_sample;
          primed = 1'b1;
        end
        window_copy[write_slot] = in_sample;
        write_slot = (write_slot == WINDOW - 1) ? 0 : write_slot + 1;
        expected_medians.push_back(window_median());
      end
      if (out_valid && !out_stall) begin
        if (expected_medians.size() == 0) begin
          $error("median: expected none, actual %0h", out_median);
          error_count++;
        end else begin
          want = expected_medians.pop_front();
          if (out_median !== want) begin
            $error("median: expected %0h, actual %0h", want, out_median);
            error_count++;
          end
        end
      end
    end
    mismatches      <= error_count;
    medians_pending <= expected_medians.size();
  end

endmodule

/* test/tb_top.sv */
// Top of the running median filter testbench: clock, reset, sample stimulus and stall pattern.
// Depends on swmf_pkg, sliding_window_median_filter_core and swmf_median_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import swmf_pkg::*;

  localparam int WINDOW       = 10;
  localparam int RANDOM_WORDS = 1250;
  // Long enough that the block fills up and has to stall its input.
  localparam int LONG_HOLD    = 96;

  // Stall patterns for the receiving side.
  typedef enum int {FLOW, SPOTTY, ALTERNATE, HOLD} stall_mode_e;

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  sample_t in_sample = '0;
  logic    out_stall = 1'b0;
  logic    in_stall;
  logic    out_valid;
  sample_t out_median;

  int mismatches;
  int medians_pending;
  int burst_left = 0;

  // Directed words: the first word after reset (which fills the window),
  // the field extremes, alternating extremes that put the median on either
  // side, a run of equal words, and single-bit and checkerboard patterns.
  sample_t directed_words [23] = '{
    16'h1234, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
    16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0007, 16'h0007, 16'h0007,
    16'h0007, 16'h0007, 16'h0007, 16'hAAAA, 16'h5555, 16'h8000, 16'h0001,
    16'h7FFF, 16'hFFFE
  };

  always #1 clk = ~clk;

  sliding_window_median_filter_core #(
    .WINDOW(WINDOW)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_median(out_median)
  );

  swmf_median_checker #(
    .WINDOW(WINDOW)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_median     (out_median),
    .mismatches     (mismatches),
    .medians_pending(medians_pending)
  );

  // Half of the words are full-range, a good share are small values so that the
  // window often holds ties, plus words hugging either end of the range.
  function automatic sample_t random_sample();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return sample_t'($urandom);
    if (pick < 8) return sample_t'($urandom_range(0, 15));
    if (pick < 9) return sample_t'($urandom_range(0, 3));
    return sample_t'(16'hFFFF - $urandom_range(0, 3));
  endfunction

  // Offers one word and returns at the edge where it is taken. The sender
  // works in bursts; when a burst runs out it usually drops valid for a
  // random gap, and sometimes runs straight into the next burst.
  task automatic send_word(input sample_t word);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_sample <= word;
    do @(posedge clk); while (in_stall);
  endtask

  // Stimulus and verdict. Reset is asserted at the start and released once.
  initial begin : stimulus
    sample_t word;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_words[i]) send_word(directed_words[i]);
    word = '0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // Halfway through, the sender goes quiet until every median is out,
      // then resumes with a fresh burst.
      if (n == RANDOM_WORDS / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (medians_pending != 0);
        burst_left = 0;
      end
      // Now and then the previous word is repeated to build runs of ties.
      if ($urandom_range(0, 19) != 0) word = random_sample();
      send_word(word);
    end
    in_valid <= 1'b0;
    // The first edge lets the checker count the last accepted word.
    do @(posedge clk); while (medians_pending != 0);
    repeat (WINDOW + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("sliding_window_median_filter_core: match");
    end else begin
      $display("sliding_window_median_filter_core: mismatch");
    end
    $finish;
  end

  // The receiver runs through segments of different stall patterns on its
  // own schedule. The third segment is always a long hold so that the block
  // backs up while the sender keeps offering; other holds come at random.
  initial begin : receiver
    int          segment;
    int          span;
    int          pick;
    stall_mode_e mode;
    segment = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      pick = $urandom_range(0, 9);
      if (segment == 2 || pick == 9) mode = HOLD;
      else if (pick < 3) mode = FLOW;
      else if (pick < 7) mode = SPOTTY;
      else mode = ALTERNATE;
      span = (mode == HOLD) ? LONG_HOLD : $urandom_range(16, 100);
      for (int c = 0; c < span; c++) begin
        case (mode)
          FLOW:      out_stall <= 1'b0;
          SPOTTY:    out_stall <= ($urandom_range(0, 2) == 0);
          ALTERNATE: out_stall <= c[0];
          default:   out_stall <= (c < span - 1);
        endcase
        @(posedge clk);
      end
      segment++;
    end
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin : watchdog
    #1_000_000;
    $display("sliding_window_median_filter_core: mismatch");
    $finish;
  end

endmodule

/* sliding_window_median_filter_core.f */
+incdir+rtl
rtl/swmf_pkg.sv
rtl/swmf_cell.sv
rtl/sliding_window_median_filter_core.sv
test/swmf_median_checker.sv
test/tb_top.sv
